[hdl/lfu_cache_with_lru_tiebreak_top_defines.svh]
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared concurrent assertion helpers for the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define LFU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication from a cause to an effect in the following cycle.
`define LFU_ASSERT_NEXT(lbl, clk, rstn, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
    else $error(msg);

`endif

[hdl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes, opcodes and the command and status records shared by the cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic [IDX_W-1:0] idx;
    logic             commit;
  } lfu_cmd_t;

  typedef struct packed {
    logic out_busy;
  } lfu_sts_t;

endpackage

[hdl/lfu_req_if.sv]
// ----------------------------------------------------------------------------
// LFU cache channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  import lfu_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] value;
  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              evicted;
  logic [DATA_W-1:0] evicted_key;
  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences capture, the serial entry scan and the commit of each request.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  lfu_sts_t sts_i,
  output lfu_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (idx_q == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        // The result register must be free before the update is applied.
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

[hdl/lfu_dpath.sv]
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry storage, scan trackers, replacement update and the result register.
// ----------------------------------------------------------------------------
`include "lfu_cache_with_lru_tiebreak_top_defines.svh"

module lfu_dpath
  import lfu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfu_cmd_t          cmd_i,
  output lfu_sts_t          sts_o,
  input  logic              req_opcode_i,
  input  logic [DATA_W-1:0] req_key_i,
  input  logic [DATA_W-1:0] req_value_i,
  input  logic              cfg_valid_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output logic              rsp_hit_o,
  output logic [DATA_W-1:0] rsp_read_value_o,
  output logic              rsp_evicted_o,
  output logic [DATA_W-1:0] rsp_evicted_key_o
);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [DATA_W-1:0]  key_q   [ENTRIES];
  logic [DATA_W-1:0]  value_q [ENTRIES];
  logic [CNT_W-1:0]   cnt_q   [ENTRIES];
  logic [IDX_W-1:0]   rank_q  [ENTRIES];
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [CAP_W-1:0]   cap_q;

  // Captured request.
  logic              op_q;
  logic [DATA_W-1:0] k_q, v_q;

  // Scan trackers.
  logic              found_q;
  logic [IDX_W-1:0]  slot_q;
  logic [IDX_W-1:0]  slot_rank_q;
  logic [DATA_W-1:0] rdval_q;
  logic              have_q;
  logic [IDX_W-1:0]  best_q;
  logic [CNT_W-1:0]  best_cnt_q;
  logic [IDX_W-1:0]  best_rank_q;
  logic [DATA_W-1:0] best_key_q;
  logic              free_found_q;
  logic [IDX_W-1:0]  free_q;

  logic              out_valid_q;
  logic              out_hit_q, out_ev_q;
  logic [DATA_W-1:0] out_rv_q, out_ek_q;

  logic              cap_zero, full;
  logic              do_touch, do_evict, do_fill;
  logic [IDX_W-1:0]  wr_slot;

  assign cap_zero = (cap_q == '0);
  assign full     = (32'(cap_q) > ENTRIES) ? (32'(occ_q) >= ENTRIES)
                                          : (32'(occ_q) >= 32'(cap_q));

  // Kinds of update applied at commit.
  assign do_touch = found_q && ((op_q == OP_GET) || !cap_zero);
  assign do_evict = (op_q == OP_PUT) && !cap_zero && !found_q && full && have_q;
  assign do_fill  = (op_q == OP_PUT) && !cap_zero && !found_q && !full && free_found_q;
  assign wr_slot  = do_evict ? best_q : free_q;

  assign sts_o.out_busy = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(ENTRIES > 16 ? 16 : ENTRIES);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= req_opcode_i;
      k_q          <= req_key_i;
      v_q          <= req_value_i;
      found_q      <= 1'b0;
      have_q       <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (valid_q[cmd_i.idx] && key_q[cmd_i.idx] == k_q && !found_q) begin
        found_q     <= 1'b1;
        slot_q      <= cmd_i.idx;
        slot_rank_q <= rank_q[cmd_i.idx];
        rdval_q     <= value_q[cmd_i.idx];
      end
      if (valid_q[cmd_i.idx] && (!have_q || cnt_q[cmd_i.idx] < best_cnt_q ||
          (cnt_q[cmd_i.idx] == best_cnt_q && rank_q[cmd_i.idx] > best_rank_q))) begin
        have_q      <= 1'b1;
        best_q      <= cmd_i.idx;
        best_cnt_q  <= cnt_q[cmd_i.idx];
        best_rank_q <= rank_q[cmd_i.idx];
        best_key_q  <= key_q[cmd_i.idx];
      end
      if (!valid_q[cmd_i.idx] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_q       <= cmd_i.idx;
      end
    end
  end

  // Entry storage: each lane updates its own rank in parallel at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (do_touch) begin
          if (IDX_W'(j) == slot_q) begin
            rank_q[j] <= '0;
          end else if (valid_q[j] && rank_q[j] < slot_rank_q) begin
            rank_q[j] <= rank_q[j] + 1'b1;
          end
        end else if (do_evict) begin
          if (IDX_W'(j) == best_q) begin
            rank_q[j] <= '0;
          end else if (valid_q[j] && rank_q[j] <= best_rank_q) begin
            // Only ranks up to the victim's move up; ranks behind it keep their place, so no gap is left.
            rank_q[j] <= rank_q[j] + 1'b1;
          end
        end else if (do_fill) begin
          if (IDX_W'(j) == free_q) begin
            rank_q[j] <= '0;
          end else if (valid_q[j]) begin
            rank_q[j] <= rank_q[j] + 1'b1;
          end
        end
      end
      if (do_touch) begin
        if (cnt_q[slot_q] != '1) begin
          cnt_q[slot_q] <= cnt_q[slot_q] + 1'b1;
        end
        if (op_q == OP_PUT) begin
          value_q[slot_q] <= v_q;
        end
      end
      if (do_evict || do_fill) begin
        key_q[wr_slot]   <= k_q;
        value_q[wr_slot] <= v_q;
        cnt_q[wr_slot]   <= CNT_W'(1);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    if (cmd_i.commit && do_fill) begin
      valid_d[free_q] = 1'b1;
      occ_d           = occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q <= do_touch;
      out_ev_q  <= do_evict;
      out_ek_q  <= do_evict ? best_key_q : '0;
      if (op_q == OP_GET) begin
        out_rv_q <= found_q ? rdval_q : '1;
      end else begin
        out_rv_q <= '0;
      end
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_hit_o         = out_hit_q;
  assign rsp_read_value_o  = out_rv_q;
  assign rsp_evicted_o     = out_ev_q;
  assign rsp_evicted_key_o = out_ek_q;

  `LFU_ASSERT(a_occ_bound, clk_i, rst_ni, (32'(occ_q) <= ENTRIES), "occupancy above size")
  `LFU_ASSERT(a_occ_match, clk_i, rst_ni, ($countones(valid_q) == 32'(occ_q)), "occupancy mismatch")
  `LFU_ASSERT(a_commit_free, clk_i, rst_ni, (cmd_i.commit |-> !out_valid_q), "commit over busy result")
  `LFU_ASSERT_NEXT(a_commit_out, clk_i, rst_ni, cmd_i.commit, out_valid_q, "result not presented")

endmodule

[hdl/lfu_cache_with_lru_tiebreak_top.sv]
// A request is accepted in the idle state, then scanned against all 16 entries one by one and
// committed; its response is then registered. No new request is accepted before that commit.
// A finished response waits in its own register, and the next request is accepted meanwhile;
// its commit then waits until that response has been taken.
// Reset clears all valid bits and occupancy at once; capacity resets to 16.
// ----------------------------------------------------------------------------
// LFU cache top level
// Key/value cache with least-frequently-used replacement and recency tie-break.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak_top
  import lfu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp,
  lfu_cfg_if.sink   cfg
);

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  assign cfg.ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfu_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_opcode_i      (req.opcode),
    .req_key_i         (req.key),
    .req_value_i       (req.value),
    .cfg_valid_i       (cfg.valid),
    .cfg_data_i        (cfg.data),
    .rsp_ready_i       (rsp.ready),
    .rsp_valid_o       (rsp.valid),
    .rsp_hit_o         (rsp.hit),
    .rsp_read_value_o  (rsp.read_value),
    .rsp_evicted_o     (rsp.evicted),
    .rsp_evicted_key_o (rsp.evicted_key)
  );

endmodule

[bench/lfu_cache_with_lru_tiebreak_top_test.sv]
// ----------------------------------------------------------------------------
// LFU cache with recency tie-break: self-checking testbench
// A table of directed requests is followed by random get/put traffic over a
// small pool of keys, under several capacity settings. Both channels idle at
// random. Each response is compared with a typed answer or an in-bench model of the cache.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned POOL_SIZE      = 24;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  hit;
    word_t read_value;
    logic  evicted;
    word_t evicted_key;
  } answer_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CFG, ROW_REQ_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       opcode;
    word_t      key;
    word_t      value;
    logic [4:0] cap;
    answer_t    answer;
  } row_t;

  logic clk;
  logic rst_n;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();
  lfu_cfg_if cfg_ch ();

  lfu_cache_with_lru_tiebreak_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the cache contents.
  logic        slot_valid [ENTRIES];
  word_t       slot_key   [ENTRIES];
  word_t       slot_value [ENTRIES];
  logic [31:0] slot_uses  [ENTRIES];
  int unsigned slot_age   [ENTRIES];
  int unsigned occupancy;
  logic [4:0]  capacity;

  answer_t pending_answers[$];
  int unsigned mismatches;
  bit          failed;
  bit          no_idle;
  bit          hold_request;
  word_t       key_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void touch_slot(int unsigned i);
    if (slot_uses[i] != 32'hFFFF_FFFF) slot_uses[i]++;
    for (int j = 0; j < ENTRIES; j++) begin
      if (slot_valid[j] && slot_age[j] < slot_age[i]) slot_age[j]++;
    end
    slot_age[i] = 0;
  endfunction

  function automatic void insert_slot(int unsigned i, word_t k, word_t v);
    for (int j = 0; j < ENTRIES; j++) begin
      if (slot_valid[j]) slot_age[j]++;
    end
    slot_valid[i] = 1'b1;
    slot_key[i]   = k;
    slot_value[i] = v;
    slot_uses[i]  = 32'd1;
    slot_age[i]   = 0;
    occupancy++;
  endfunction

  function automatic answer_t cache_access(logic op, word_t k, word_t v);
    answer_t     a;
    int unsigned cap;
    int unsigned slot;
    int unsigned victim;
    bit          found;
    bit          have;
    a     = '0;
    cap   = (capacity > ENTRIES) ? ENTRIES : capacity;
    found = 1'b0;
    slot  = 0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (!found && slot_valid[j] && slot_key[j] == k) begin
        found = 1'b1;
        slot  = j;
      end
    end
    if (op == OP_GET) begin
      if (found) begin
        a.hit        = 1'b1;
        a.read_value = slot_value[slot];
        touch_slot(slot);
      end else begin
        a.read_value = '1;
      end
      return a;
    end
    if (cap == 0) return a;
    if (found) begin
      a.hit            = 1'b1;
      slot_value[slot] = v;
      touch_slot(slot);
      return a;
    end
    if (occupancy >= cap) begin
      have   = 1'b0;
      victim = 0;
      for (int j = 0; j < ENTRIES; j++) begin
        if (slot_valid[j] && (!have || slot_uses[j] < slot_uses[victim] ||
            (slot_uses[j] == slot_uses[victim] && slot_age[j] > slot_age[victim]))) begin
          victim = j;
          have   = 1'b1;
        end
      end
      if (have) begin
        a.evicted     = 1'b1;
        a.evicted_key = slot_key[victim];
        for (int j = 0; j < ENTRIES; j++) begin
          if (slot_valid[j] && slot_age[j] > slot_age[victim]) slot_age[j]--;
        end
        slot_valid[victim] = 1'b0;
        occupancy--;
        insert_slot(victim, k, v);
      end
      return a;
    end
    for (int j = 0; j < ENTRIES; j++) begin
      if (!slot_valid[j]) begin
        insert_slot(j, k, v);
        break;
      end
    end
    return a;
  endfunction

  // Drives one request; returns at the edge where it was accepted.
  task automatic send_request(logic op, word_t k, word_t v, bit typed, answer_t typed_answer);
    answer_t a;
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk); while (!req_ch.ready);
    a = cache_access(op, k, v);
    pending_answers.push_back(typed ? typed_answer : a);
  endtask

  task automatic sender_gap();
    int unsigned n;
    if (no_idle || $urandom_range(0, 5) != 0) return;
    n = $urandom_range(1, 15);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    capacity = cap;
  endtask

  // Response side: checks, and paces ready with random stalls or a long hold-off.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    answer_t got;
    answer_t want;
    stall_left    = 0;
    hold_left     = 0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key};
        if (pending_answers.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("Unexpected response %p", got);
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("Response mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (no_idle || !rst_n) begin
        rsp_ch.ready <= rst_n;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    row_t        rows[$];
    logic [4:0]  phase_caps[8];
    word_t       k;
    word_t       v;
    logic        op;
    rst_n         = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.opcode = OP_GET;
    req_ch.key    = '0;
    req_ch.value  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    mismatches    = 0;
    failed        = 1'b0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    capacity      = 5'd16;
    occupancy     = 0;
    for (int j = 0; j < ENTRIES; j++) begin
      slot_valid[j] = 1'b0;
      slot_key[j]   = '0;
      slot_value[j] = '0;
      slot_uses[j]  = '0;
      slot_age[j]   = 0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    for (int j = 4; j < POOL_SIZE; j++) key_pool[j] = $urandom();

    // Directed table: typed answers where they are plain, the model elsewhere.
    rows = '{
      '{ROW_REQ_TYPED, OP_GET, 32'h0000_0000, 32'h0, 5'd0, '{1'b0, '1, 1'b0, '0}},
      '{ROW_REQ_TYPED, OP_GET, 32'h8000_0000, 32'h0, 5'd0, '{1'b0, '1, 1'b0, '0}},
      '{ROW_REQ_TYPED, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, '0},
      '{ROW_REQ_TYPED, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, '0},
      '{ROW_REQ_TYPED, OP_GET, 32'h7FFF_FFFF, 32'h0, 5'd0,
        '{1'b1, 32'h8000_0000, 1'b0, '0}},
      '{ROW_REQ_TYPED, OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0,
        '{1'b1, 32'h7FFF_FFFF, 1'b0, '0}},
      '{ROW_REQ_TYPED, OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0,
        '{1'b1, '0, 1'b0, '0}},
      '{ROW_REQ_TYPED, OP_GET, 32'h7FFF_FFFF, 32'h0, 5'd0, '{1'b1, '1, 1'b0, '0}},
      '{ROW_REQ, OP_PUT, 32'h0000_0000, 32'h0000_0000, 5'd0, '0},
      '{ROW_REQ, OP_PUT, 32'hFFFF_FFFF, 32'h0000_0001, 5'd0, '0},
      '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0, 5'd0, '0},
      '{ROW_CFG, OP_GET, 32'h0, 32'h0, 5'd0, '0},
      // With no capacity a put answers all zero, but gets still hit.
      '{ROW_REQ_TYPED, OP_PUT, 32'h1234_5678, 32'h5555_AAAA, 5'd0, '0},
      '{ROW_REQ, OP_GET, 32'hFFFF_FFFF, 32'h0, 5'd0, '0},
      '{ROW_CFG, OP_GET, 32'h0, 32'h0, 5'd1, '0},
      // Capacity now below occupancy: each new key evicts exactly one entry.
      '{ROW_REQ, OP_PUT, 32'h1234_5678, 32'hAAAA_5555, 5'd0, '0},
      '{ROW_REQ, OP_PUT, 32'h0BAD_F00D, 32'h0000_0002, 5'd0, '0},
      '{ROW_REQ, OP_GET, 32'h1234_5678, 32'h0, 5'd0, '0},
      '{ROW_CFG, OP_GET, 32'h0, 32'h0, 5'd31, '0},
      '{ROW_REQ, OP_PUT, 32'h0000_0003, 32'h0000_0003, 5'd0, '0},
      '{ROW_REQ, OP_GET, 32'h0BAD_F00D, 32'h0, 5'd0, '0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG)
        write_capacity(rows[i].cap);
      else
        send_request(rows[i].opcode, rows[i].key, rows[i].value,
                     rows[i].kind == ROW_REQ_TYPED, rows[i].answer);
    end

    phase_caps = '{5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd7, 5'd2, 5'd16};
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      no_idle = (p == 7);
      // Ask the response side for a long hold-off while requests keep coming.
      if (p == 1) hold_request = 1'b1;
      for (int n = 0; n < 185; n++) begin
        op = $urandom_range(0, 1);
        k  = ($urandom_range(0, 9) == 0) ? word_t'($urandom()) :
             key_pool[$urandom_range(0, POOL_SIZE - 1)];
        v  = $urandom();
        send_request(op, k, v, 1'b0, '0);
        // Once mid-phase, wait for the cache to drain completely.
        if (p == 3 && n == 90) begin
          req_ch.valid <= 1'b0;
          while (pending_answers.size() != 0) @(posedge clk);
        end else begin
          sender_gap();
        end
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_req_if.sv
hdl/lfu_ctrl.sv
hdl/lfu_dpath.sv
hdl/lfu_cache_with_lru_tiebreak_top.sv
bench/lfu_cache_with_lru_tiebreak_top_test.sv
